[design/csc_pkg.sv]
// ---------------------------------------------------------------------------
// csc_pkg - shared types and constants
// Sequencer states, register indexes and fixed scaling constants for the
// cycling speed/cadence packet parser.
// ---------------------------------------------------------------------------
package csc_pkg;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  // bytes held for parsing: flag byte plus at most ten field bytes
  localparam int SLOTS = 11;
  localparam int SW    = 4;

  localparam int NUM_W = 58;
  localparam int DEN_W = 21;

  localparam logic [19:0] CAD_SCALE    = 20'd614400;
  localparam logic [15:0] JIT_DT_LIMIT = 16'd103;   // 10*dt < 1024

  localparam logic [11:0] CIRC_RST = 12'd2096;
  localparam logic [15:0] MIN_RST  = 16'd1;
  localparam logic [15:0] MAX_RST  = 16'd10240;
  localparam logic [15:0] VMAX_RST = 16'd10000;

  // update mask bits
  localparam int MB_SPEED = 0;
  localparam int MB_CAD   = 1;
  localparam int MB_WREVS = 2;
  localparam int MB_WTIME = 3;
  localparam int MB_CREVS = 4;
  localparam int MB_CTIME = 5;

  // flag byte bits
  localparam int FB_WREVS = 0;
  localparam int FB_WTIME = 1;
  localparam int FB_CREVS = 2;
  localparam int FB_CTIME = 3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_CIRC = 2'd0,
    CFG_MIN  = 2'd1,
    CFG_MAX  = 2'd2,
    CFG_VMAX = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_CAPT,
    S_PLAN,
    S_SPD,
    S_SM1,
    S_SM2,
    S_SM3,
    S_CAD,
    S_DIVI,
    S_DIV,
    S_DONE
  } state_t;

endpackage

[design/csc_in_if.sv]
// ---------------------------------------------------------------------------
// csc_in_if - packet byte channel
// One packet byte per word, with a flag on the final byte.
// ---------------------------------------------------------------------------
interface csc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

[design/csc_out_if.sv]
// ---------------------------------------------------------------------------
// csc_out_if - parse result channel
// One word per packet: update mask, computed values, raw fields, status.
// ---------------------------------------------------------------------------
interface csc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  update_mask;
  logic [15:0] speed_centi_kmh;
  logic [15:0] cadence_deci_rpm;
  logic [31:0] wheel_revs;
  logic [15:0] wheel_time;
  logic [15:0] crank_revs;
  logic [15:0] crank_time;
  logic        status;

  modport source (output valid, update_mask, speed_centi_kmh, cadence_deci_rpm,
                  wheel_revs, wheel_time, crank_revs, crank_time, status,
                  input ready);
  modport sink   (input valid, update_mask, speed_centi_kmh, cadence_deci_rpm,
                  wheel_revs, wheel_time, crank_revs, crank_time, status,
                  output ready);
endinterface

[design/cycling_speed_cadence_parser_core.sv]
// ---------------------------------------------------------------------------
// cycling_speed_cadence_parser_core - speed/cadence notification parser
// Collects packet bytes, then decodes flags and fields and derives speed
// and cadence with one shared restoring divider.
// ---------------------------------------------------------------------------
// Usage:
//  in_ch carries one packet byte per word, last_byte set on the final one.
//  A non-last byte is taken and yields nothing. The last byte
//  starts the parse, during which in_ch.ready is low:
//    S_FETCH then S_CAPT for each stored byte fetched (up to 11 bytes,
//    memory read port), decode in S_PLAN, speed set-up in S_SPD and
//    S_SM1 to S_SM3, cadence set-up in S_CAD, each division in S_DIVI
//    (saturated) or S_DIVI then S_DIV (16 quotient bits, one a cycle),
//    and loading the result word in S_DONE.
//  One word per packet appears on out_ch and is held until taken. Bytes of
//  the next packet are accepted while it waits; a further parse stalls in
//  its final state until the pending word has gone.
//  Configuration writes on cfg_* take effect at the next edge; the user
//  makes them only while the block is idle, which the block does not enforce.
//  Reset (rst_n low, synchronous) clears the byte count, the previous
//  wheel and crank samples and the configuration to its defaults.
// ---------------------------------------------------------------------------
module cycling_speed_cadence_parser_core #(
  parameter int PACKET_BYTES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  csc_in_if.sink                      in_ch,
  csc_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [csc_pkg::CFG_IW-1:0]  cfg_idx,
  input  logic [csc_pkg::CFG_DW-1:0]  cfg_data
);
  import csc_pkg::*;

  localparam int LW = $clog2(PACKET_BYTES + 1);
  localparam int AW = $clog2(PACKET_BYTES);
  localparam int LX = LW + 1;

  state_t state_r, state_nxt;

  logic [11:0] circ_r;
  logic [15:0] min_r, max_r, vmax_r;

  logic [LW-1:0] cnt_r;
  logic [LW-1:0] len_r;
  logic [7:0]    mem [PACKET_BYTES];
  logic [7:0]    mem_q;
  logic [SW-1:0] rd_idx_r;
  logic [7:0]    slot_r [SLOTS];

  logic [31:0] pwr_r;
  logic [15:0] pwt_r, pcr_r, pct_r;

  logic [5:0]  mask_r;
  logic        status_r, do_spd_r, do_cad_r;
  logic [31:0] wr_r;
  logic [15:0] wt_r, cv_r, ct_r;

  logic [43:0]      prod_r;
  logic             jit_r;
  logic [36:0]      msd_r;
  logic [NUM_W-1:0] div_num_r;
  logic [DEN_W-1:0] div_den_r;
  logic [DEN_W:0]   div_rem_r;
  logic [15:0]      div_q_r;
  logic [4:0]       div_cnt_r;
  logic             div_sel_r;    // 0 speed, 1 cadence
  logic [15:0]      spd_r, cad_r;

  logic        out_valid_r;
  logic [5:0]  o_mask_r;
  logic [15:0] o_spd_r, o_cad_r, o_wt_r, o_cr_r, o_ct_r;
  logic [31:0] o_wr_r;
  logic        o_stat_r;

  // handshakes
  logic in_acc, done_load;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign done_load   = (state_r == S_DONE) & (~out_valid_r | out_ch.ready);

  // byte fetch
  logic [LW-1:0] len_acc;
  logic          last_rd;
  assign len_acc = (cnt_r < LW'(PACKET_BYTES)) ? cnt_r + LW'(1) : cnt_r;
  assign last_rd = (LW'(rd_idx_r) + LW'(1) >= len_r) || (rd_idx_r == SW'(SLOTS - 1));

  // ---- decode of the stored packet ----
  logic [7:0]  flg;
  logic [2:0]  off1;
  logic [LX-1:0] lx, o2, o4;
  logic [15:0] g1, g3, g5, g7, g9, d_cv, d_ct2, d_ct, d_wt;
  logic [5:0]  d_mask;
  logic        d_stat, d_spd, d_cad, d_stop;

  assign flg  = slot_r[0];
  assign off1 = {flg[FB_WREVS], flg[FB_WTIME], 1'b1};
  assign lx   = {1'b0, len_r};
  assign o2   = LX'(off1) + LX'(2);
  assign o4   = LX'(off1) + LX'(4);
  assign g1   = {slot_r[2], slot_r[1]};
  assign g3   = {slot_r[4], slot_r[3]};
  assign g5   = {slot_r[6], slot_r[5]};
  assign g7   = {slot_r[8], slot_r[7]};
  assign g9   = {slot_r[10], slot_r[9]};
  assign d_wt = flg[FB_WREVS] ? g5 : g1;
  assign d_ct = (flg[FB_CREVS] | ~flg[FB_CTIME]) ? d_ct2 : d_cv;

  always_comb begin
    case ({flg[FB_WREVS], flg[FB_WTIME]})
      2'b00:   begin d_cv = g1; d_ct2 = g3; end
      2'b01:   begin d_cv = g3; d_ct2 = g5; end
      2'b10:   begin d_cv = g5; d_ct2 = g7; end
      default: begin d_cv = g7; d_ct2 = g9; end
    endcase
  end

  always_comb begin
    d_mask = '0;
    d_stat = 1'b0;
    d_spd  = 1'b0;
    d_cad  = 1'b0;
    d_stop = 1'b0;
    if (flg[FB_WREVS]) begin
      if (lx < LX'(5)) begin
        d_stop = 1'b1;
      end else begin
        d_mask[MB_WREVS] = 1'b1;
        if (flg[FB_WTIME]) begin
          if (lx < LX'(7)) begin
            d_stop = 1'b1;
          end else begin
            d_mask[MB_SPEED] = 1'b1;
            d_mask[MB_WTIME] = 1'b1;
            d_spd = 1'b1;
          end
        end
      end
    end else if (flg[FB_WTIME]) begin
      if (lx < LX'(3)) d_stop = 1'b1;
      else d_mask[MB_WTIME] = 1'b1;
    end
    d_stat = d_stop;
    if (!d_stop) begin
      if (flg[FB_CREVS]) begin
        if (o2 > lx) begin
          d_stat = 1'b1;
        end else begin
          d_mask[MB_CREVS] = 1'b1;
          if (flg[FB_CTIME]) begin
            if (o4 > lx) begin
              d_stat = 1'b1;
            end else begin
              d_mask[MB_CAD]   = 1'b1;
              d_mask[MB_CTIME] = 1'b1;
              d_cad = 1'b1;
            end
          end
        end
      end else if (flg[FB_CTIME]) begin
        if (o2 > lx) d_stat = 1'b1;
        else d_mask[MB_CTIME] = 1'b1;
      end else if (o2 <= lx) begin
        // unflagged crank data left in the packet
        if (o4 <= lx) begin
          if (d_ct != 16'd0) begin
            d_mask[MB_CAD]   = 1'b1;
            d_mask[MB_CREVS] = 1'b1;
            d_mask[MB_CTIME] = 1'b1;
            d_cad = 1'b1;
          end
        end else begin
          d_mask[MB_CREVS] = 1'b1;
        end
      end
    end
  end

  // ---- speed / cadence decisions ----
  logic [15:0] w_dt, c_dt;
  logic        w_first, w_zero, w_out, go_mul, c_first, c_zero, go_cad;
  logic        st_wheel, st_crank, jit_rej;
  assign w_dt    = wt_r - pwt_r;
  assign c_dt    = ct_r - pct_r;
  assign w_first = (pwt_r == 16'd0);
  assign w_zero  = (w_dt == 16'd0);
  assign w_out   = (w_dt < min_r) || (w_dt > max_r);
  assign go_mul  = ~w_first & ~w_zero & ~w_out;
  assign c_first = (pct_r == 16'd0);
  assign c_zero  = (c_dt == 16'd0);
  assign go_cad  = ~c_first & ~c_zero;
  assign st_wheel = (state_r == S_SPD) & do_spd_r & (w_first | ~w_zero);
  assign st_crank = (state_r == S_CAD) & do_cad_r & (c_first | ~c_zero);
  assign jit_rej  = jit_r & (div_num_r > NUM_W'(msd_r));

  // ---- shared divider ----
  logic           div_sat, div_ge, div_fin;
  logic [DEN_W:0] rem2;
  logic [15:0]    q_fin;
  assign div_sat = div_num_r[NUM_W-1:16] >= (NUM_W-16)'(div_den_r);
  assign rem2    = {div_rem_r[DEN_W-1:0], div_num_r[15]};
  assign div_ge  = rem2 >= {1'b0, div_den_r};
  assign div_fin = ((state_r == S_DIVI) & div_sat) |
                   ((state_r == S_DIV) & (div_cnt_r == 5'd1));
  assign q_fin   = (state_r == S_DIVI) ? 16'hFFFF : {div_q_r[14:0], div_ge};

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc && in_ch.last_byte) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_CAPT;
      S_CAPT:  state_nxt = last_rd ? S_PLAN : S_FETCH;
      S_PLAN:  state_nxt = S_SPD;
      S_SPD:   state_nxt = (do_spd_r && go_mul) ? S_SM1 : S_CAD;
      S_SM1:   state_nxt = S_SM2;
      S_SM2:   state_nxt = S_SM3;
      S_SM3:   state_nxt = jit_rej ? S_CAD : S_DIVI;
      S_CAD:   state_nxt = (do_cad_r && go_cad) ? S_DIVI : S_DONE;
      S_DIVI:  if (div_sat) state_nxt = div_sel_r ? S_DONE : S_CAD;
               else state_nxt = S_DIV;
      S_DIV:   if (div_cnt_r == 5'd1) state_nxt = div_sel_r ? S_DONE : S_CAD;
      S_DONE:  if (done_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pwr_r       <= '0;
      pwt_r       <= '0;
      pcr_r       <= '0;
      pct_r       <= '0;
      circ_r      <= CIRC_RST;
      min_r       <= MIN_RST;
      max_r       <= MAX_RST;
      vmax_r      <= VMAX_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_CIRC: circ_r <= cfg_data[11:0];
          CFG_MIN:  min_r  <= cfg_data;
          CFG_MAX:  max_r  <= cfg_data;
          CFG_VMAX: vmax_r <= cfg_data;
          default:  ;
        endcase
      end
      if (in_acc) begin
        if (in_ch.last_byte) cnt_r <= '0;
        else cnt_r <= len_acc;
      end
      if (st_wheel) begin
        pwr_r <= wr_r;
        pwt_r <= wt_r;
      end
      if (st_crank) begin
        pcr_r <= cv_r;
        pct_r <= ct_r;
      end
      if (done_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // packet store
  always_ff @(posedge clk) begin
    if (in_acc && (cnt_r < LW'(PACKET_BYTES))) mem[cnt_r[AW-1:0]] <= in_ch.data_byte;
    mem_q <= mem[AW'(rd_idx_r)];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.last_byte) begin
          len_r    <= len_acc;
          rd_idx_r <= '0;
        end
      end
      S_CAPT: begin
        if (rd_idx_r < SW'(SLOTS)) slot_r[rd_idx_r] <= mem_q;
        rd_idx_r <= rd_idx_r + SW'(1);
      end
      S_PLAN: begin
        mask_r   <= d_mask;
        status_r <= d_stat;
        do_spd_r <= d_spd;
        do_cad_r <= d_cad;
        wr_r     <= {g3, g1};
        wt_r     <= d_wt;
        cv_r     <= d_cv;
        ct_r     <= d_ct;
        spd_r    <= '0;
        cad_r    <= '0;
      end
      S_SPD: begin
        // rev difference wraps at 32 bits before scaling
        prod_r    <= 32'(wr_r - pwr_r) * circ_r;
        div_den_r <= (DEN_W'(w_dt) << 4) + (DEN_W'(w_dt) << 3) + DEN_W'(w_dt);
        jit_r     <= w_dt < JIT_DT_LIMIT;
      end
      S_SM1: begin
        // times 9216 = 8192 + 1024
        div_num_r <= (NUM_W'(prod_r) << 13) + (NUM_W'(prod_r) << 10);
      end
      S_SM2: begin
        msd_r <= vmax_r * div_den_r;
      end
      S_SM3: begin
        div_sel_r <= 1'b0;
      end
      S_CAD: begin
        div_sel_r <= 1'b1;
        div_num_r <= NUM_W'(16'(cv_r - pcr_r) * CAD_SCALE);
        div_den_r <= DEN_W'(c_dt);
      end
      S_DIVI: begin
        div_rem_r <= {1'b0, div_num_r[DEN_W+15:16]};
        div_q_r   <= '0;
        div_cnt_r <= 5'd16;
      end
      S_DIV: begin
        div_rem_r <= div_ge ? rem2 - {1'b0, div_den_r} : rem2;
        div_q_r   <= {div_q_r[14:0], div_ge};
        div_num_r <= div_num_r << 1;
        div_cnt_r <= div_cnt_r - 5'd1;
      end
      default: ;
    endcase
    if (div_fin) begin
      if (div_sel_r) cad_r <= q_fin;
      else spd_r <= q_fin;
    end
    if (done_load) begin
      o_mask_r <= mask_r;
      o_stat_r <= status_r;
      o_spd_r  <= mask_r[MB_SPEED] ? spd_r : '0;
      o_cad_r  <= mask_r[MB_CAD]   ? cad_r : '0;
      o_wr_r   <= mask_r[MB_WREVS] ? wr_r  : '0;
      o_wt_r   <= mask_r[MB_WTIME] ? wt_r  : '0;
      o_cr_r   <= mask_r[MB_CREVS] ? cv_r  : '0;
      o_ct_r   <= mask_r[MB_CTIME] ? ct_r  : '0;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.update_mask      = o_mask_r;
  assign out_ch.speed_centi_kmh  = o_spd_r;
  assign out_ch.cadence_deci_rpm = o_cad_r;
  assign out_ch.wheel_revs       = o_wr_r;
  assign out_ch.wheel_time       = o_wt_r;
  assign out_ch.crank_revs       = o_cr_r;
  assign out_ch.crank_time       = o_ct_r;
  assign out_ch.status           = o_stat_r;

  // ---- checks ----
  a_spd_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!o_mask_r[MB_SPEED] || (o_mask_r[MB_WREVS] && o_mask_r[MB_WTIME])))
    else $error("speed reported without wheel fields");

  a_cad_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!o_mask_r[MB_CAD] || (o_mask_r[MB_CREVS] && o_mask_r[MB_CTIME])))
    else $error("cadence reported without crank fields");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ({1'b0, div_den_r} > div_rem_r))
    else $error("divider remainder out of range");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LW'(PACKET_BYTES))
    else $error("byte count beyond store depth");

endmodule

[dv/tb_cycling_speed_cadence_parser_core.sv]
// ---------------------------------------------------------------------------
// tb_cycling_speed_cadence_parser_core - packet parser testbench
// Drives byte packets through the parser and checks each parse result word
// against an in-bench packet decoder holding its own sample history.
// ---------------------------------------------------------------------------
module tb_cycling_speed_cadence_parser_core;
  import csc_pkg::*;

  localparam int PKT_BYTES = 16;

  typedef struct packed {
    logic [5:0]  mask;
    logic [15:0] speed;
    logic [15:0] cadence;
    logic [31:0] wrevs;
    logic [15:0] wtime;
    logic [15:0] crevs;
    logic [15:0] ctime;
    logic        status;
  } csc_result_t;

  class csc_scoreboard;
    logic [7:0]  pkt [PKT_BYTES];
    int unsigned nbytes;
    logic [31:0] p_wrevs;
    logic [15:0] p_wtime, p_crevs, p_ctime;
    logic [11:0] circ;
    logic [15:0] min_dt, max_dt, vmax;
    csc_result_t pending [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      nbytes = 0; p_wrevs = 0; p_wtime = 0; p_crevs = 0; p_ctime = 0;
      circ = CIRC_RST; min_dt = MIN_RST; max_dt = MAX_RST; vmax = VMAX_RST;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_CIRC: circ = v[11:0];
        CFG_MIN:  min_dt = v;
        CFG_MAX:  max_dt = v;
        CFG_VMAX: vmax = v;
        default: ;
      endcase
    endfunction

    function logic [15:0] le16(int unsigned pos);
      return {pkt[(pos + 1) % PKT_BYTES], pkt[pos % PKT_BYTES]};
    endfunction

    function logic [15:0] wheel_speed(logic [31:0] revs, logic [15:0] t);
      logic [15:0] dt;
      logic [31:0] rd;
      logic [63:0] num, den, q;
      if (p_wtime == 0) begin
        p_wrevs = revs; p_wtime = t; return 0;
      end
      dt = t - p_wtime;
      if (dt == 0) return 0;
      if (dt < min_dt || dt > max_dt) begin
        p_wrevs = revs; p_wtime = t; return 0;
      end
      rd = revs - p_wrevs;
      num = 64'(rd) * 64'(circ) * 64'd9216;
      den = 64'd25 * 64'(dt);
      p_wrevs = revs; p_wtime = t;
      if (num > 64'(vmax) * den && dt < JIT_DT_LIMIT) return 0;
      q = num / den;
      return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function logic [15:0] crank_cadence(logic [15:0] revs, logic [15:0] t);
      logic [15:0] dt, rd;
      logic [63:0] q;
      if (p_ctime == 0) begin
        p_crevs = revs; p_ctime = t; return 0;
      end
      dt = t - p_ctime;
      if (dt == 0) return 0;
      rd = revs - p_crevs;
      q = (64'(rd) * 64'(CAD_SCALE)) / 64'(dt);
      p_crevs = revs; p_ctime = t;
      return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function void decode(int unsigned len, output csc_result_t r);
      logic [7:0]  fl;
      int unsigned off;
      logic [31:0] v;
      logic [15:0] t;
      r = '0;
      fl = pkt[0];
      off = 1;
      if (fl[FB_WREVS]) begin
        if (off + 4 > len) begin r.status = 1; return; end
        v = {le16(off + 2), le16(off)};
        off += 4;
        r.wrevs = v; r.mask[MB_WREVS] = 1;
        if (fl[FB_WTIME]) begin
          if (off + 2 > len) begin r.status = 1; return; end
          t = le16(off);
          off += 2;
          r.speed = wheel_speed(v, t); r.mask[MB_SPEED] = 1;
          r.wtime = t; r.mask[MB_WTIME] = 1;
        end
      end else if (fl[FB_WTIME]) begin
        if (off + 2 > len) begin r.status = 1; return; end
        r.wtime = le16(off); r.mask[MB_WTIME] = 1;
        off += 2;
      end
      if (fl[FB_CREVS]) begin
        if (off + 2 > len) begin r.status = 1; return; end
        v = le16(off);
        off += 2;
        r.crevs = v[15:0]; r.mask[MB_CREVS] = 1;
        if (fl[FB_CTIME]) begin
          if (off + 2 > len) begin r.status = 1; return; end
          t = le16(off);
          r.cadence = crank_cadence(v[15:0], t); r.mask[MB_CAD] = 1;
          r.ctime = t; r.mask[MB_CTIME] = 1;
        end
      end else if (fl[FB_CTIME]) begin
        if (off + 2 > len) begin r.status = 1; return; end
        r.ctime = le16(off); r.mask[MB_CTIME] = 1;
      end else if (off + 2 <= len) begin
        v = le16(off);
        if (off + 4 <= len) begin
          t = le16(off + 2);
          if (t != 0) begin
            r.cadence = crank_cadence(v[15:0], t); r.mask[MB_CAD] = 1;
            r.crevs = v[15:0]; r.mask[MB_CREVS] = 1;
            r.ctime = t; r.mask[MB_CTIME] = 1;
          end
        end else begin
          r.crevs = v[15:0]; r.mask[MB_CREVS] = 1;
        end
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      csc_result_t r;
      if (nbytes < PKT_BYTES) begin
        pkt[nbytes] = b; nbytes++;
      end
      if (last) begin
        decode(nbytes, r);
        nbytes = 0;
        pending.push_back(r);
      end
    endfunction

    function void check_result(csc_result_t got);
      csc_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: exp mask %h spd %0d cad %0d wr %0d wt %0d cr %0d ct %0d st %0d",
                   checked, exp_r.mask, exp_r.speed, exp_r.cadence, exp_r.wrevs,
                   exp_r.wtime, exp_r.crevs, exp_r.ctime, exp_r.status);
        if (errors <= 10)
          $display("            got mask %h spd %0d cad %0d wr %0d wt %0d cr %0d ct %0d st %0d",
                   got.mask, got.speed, got.cadence, got.wrevs,
                   got.wtime, got.crevs, got.ctime, got.status);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_data;
  logic        idle_free;
  int unsigned stall_cycles;
  int unsigned n_pkts;

  csc_in_if  in_ch ();
  csc_out_if out_ch ();
  csc_scoreboard sb;

  cycling_speed_cadence_parser_core #(.PACKET_BYTES(PKT_BYTES)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0; cfg_we = 0; cfg_idx = '0; cfg_data = '0;
    in_ch.valid = 0; in_ch.data_byte = '0; in_ch.last_byte = 0;
    out_ch.ready = 0;
    idle_free = 0;
  end

  // result side: random back-pressure, check on every accepted word
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.update_mask, out_ch.speed_centi_kmh, out_ch.cadence_deci_rpm,
                       out_ch.wheel_revs, out_ch.wheel_time, out_ch.crank_revs,
                       out_ch.crank_time, out_ch.status});
    out_ch.ready <= idle_free || ($urandom_range(99) >= 35);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else if (rst_n) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
        $display("watchdog expired");
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // valid stays up after the word is taken; the next call may lower it or drive the next byte, and drain() lowers it
  task automatic send_byte(logic [7:0] b, logic last);
    while (!idle_free && $urandom_range(99) < 35) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.data_byte <= b; in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(b, last);
  endtask

  task automatic send_packet(logic [7:0] bytes [$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    n_pkts++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // packet per flag nibble with random upper flag bits, fields in order; trim drops trailing bytes
  task automatic build_packet(logic [3:0] fl, logic [31:0] wr, logic [15:0] wt,
                              logic [15:0] cr, logic [15:0] ct, int trim,
                              ref logic [7:0] q [$]);
    q = {};
    q.push_back({4'($urandom), fl});
    if (fl[0]) begin
      q.push_back(wr[7:0]); q.push_back(wr[15:8]);
      q.push_back(wr[23:16]); q.push_back(wr[31:24]);
    end
    if (fl[1]) begin q.push_back(wt[7:0]); q.push_back(wt[15:8]); end
    if (fl[2] || fl[3] == 0) begin q.push_back(cr[7:0]); q.push_back(cr[15:8]); end
    if (fl[3] || fl[2] == 0) begin q.push_back(ct[7:0]); q.push_back(ct[15:8]); end
    while (trim > 0 && q.size() > 1) begin void'(q.pop_back()); trim--; end
  endtask

  logic [7:0]  pq [$];
  logic [31:0] wrev;
  logic [15:0] wtim, crev, ctim;

  task automatic random_phase(int count);
    logic [3:0] fl;
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      fl = 4'($urandom);
      wrev += $urandom_range(6); wtim += 16'($urandom_range(2500));
      crev += $urandom_range(3); ctim += 16'($urandom_range(1500));
      if ($urandom_range(9) == 0) wrev = $urandom;
      if ($urandom_range(15) == 0) wtim = 16'($urandom_range(2) == 0 ? 0 : $urandom);
      if ($urandom_range(15) == 0) ctim = 16'($urandom_range(2) == 0 ? 0 : $urandom);
      if ($urandom_range(9) == 0) crev = 16'($urandom);
      if (k < 75) build_packet(fl, wrev, wtim, crev, ctim, 0, pq);
      else if (k < 88) build_packet(fl, wrev, wtim, crev, ctim, $urandom_range(1, 5), pq);
      else begin
        pq = {};
        repeat ($urandom_range(1, 22)) pq.push_back(8'($urandom));
      end
      send_packet(pq);
    end
  endtask

  initial begin
    sb = new();
    stall_cycles = 0; n_pkts = 0;
    wrev = 100; wtim = 1000; crev = 10; ctim = 500;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: first samples, normal, zero interval, truncation, fallback
    build_packet(4'hF, 32'd100, 16'd1000, 16'd10, 16'd500, 0, pq); send_packet(pq);
    build_packet(4'hF, 32'd102, 16'd2024, 16'd11, 16'd1524, 0, pq); send_packet(pq);
    build_packet(4'hF, 32'd103, 16'd2024, 16'd12, 16'd1524, 0, pq); send_packet(pq);
    build_packet(4'hF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, pq); send_packet(pq);
    build_packet(4'hF, 32'd0, 16'd0, 16'd0, 16'd0, 0, pq); send_packet(pq);
    build_packet(4'h3, 32'd50, 16'd10, 16'd0, 16'd0, 0, pq); send_packet(pq);
    build_packet(4'h3, 32'd90, 16'd20, 16'd0, 16'd0, 0, pq); send_packet(pq);
    build_packet(4'h3, 32'd95, 16'd12000, 16'd0, 16'd0, 0, pq); send_packet(pq);
    build_packet(4'h0, 32'd0, 16'd0, 16'd7, 16'd300, 0, pq); send_packet(pq);
    build_packet(4'h0, 32'd0, 16'd0, 16'd9, 16'd0, 0, pq); send_packet(pq);
    build_packet(4'h0, 32'd0, 16'd0, 16'd9, 16'd0, 2, pq); send_packet(pq);
    build_packet(4'h0, 32'd0, 16'd0, 16'd9, 16'd0, 3, pq); send_packet(pq);
    build_packet(4'h2, 32'd0, 16'd77, 16'd5, 16'd0, 0, pq); send_packet(pq);
    build_packet(4'h8, 32'd0, 16'd0, 16'd0, 16'd88, 0, pq); send_packet(pq);
    build_packet(4'h4, 32'd0, 16'd0, 16'd9, 16'd0, 0, pq); send_packet(pq);
    for (int t = 1; t <= 5; t++) begin
      build_packet(4'hF, 32'd1, 16'd1, 16'd1, 16'd1, t, pq); send_packet(pq);
    end
    pq = {};
    repeat (20) pq.push_back(8'hFF);
    send_packet(pq);
    drain();

    // register extremes
    write_reg(CFG_CIRC, 16'hFFFF); write_reg(CFG_MIN, 16'd0);
    write_reg(CFG_MAX, 16'hFFFF); write_reg(CFG_VMAX, 16'hFFFF);
    random_phase(30);
    drain();
    write_reg(CFG_CIRC, 16'd0); write_reg(CFG_MIN, 16'hFFFF);
    write_reg(CFG_MAX, 16'd0); write_reg(CFG_VMAX, 16'd0);
    random_phase(15);
    drain();
    write_reg(CFG_CIRC, 16'd2096); write_reg(CFG_MIN, 16'd1);
    write_reg(CFG_MAX, 16'd10240); write_reg(CFG_VMAX, 16'd10000);
    random_phase(20);
    drain();

    // no idling on either side for a stretch
    idle_free = 1;
    random_phase(20);
    idle_free = 0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_CIRC, 16'($urandom_range(4095)));
      write_reg(CFG_MIN, 16'($urandom_range(200)));
      write_reg(CFG_MAX, 16'($urandom_range(500, 65535)));
      write_reg(CFG_VMAX, 16'($urandom));
      random_phase(20);
      drain();
    end

    drain();
    $display("Checked %0d result words from %0d packets over several register settings.",
             sb.checked, n_pkts);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
